@@ rtl/core/tmb_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Timer bank package
// Shared types, request codes and arithmetic constants of the timer bank.
// ----------------------------------------------------------------------------
package tmb_pkg;

    // request operation codes
    localparam logic [3:0] OP_TICK     = 4'd0;
    localparam logic [3:0] OP_CREATE   = 4'd1;
    localparam logic [3:0] OP_DELETE   = 4'd2;
    localparam logic [3:0] OP_SET_TIME = 4'd3;
    localparam logic [3:0] OP_START    = 4'd4;
    localparam logic [3:0] OP_PAUSE    = 4'd5;
    localparam logic [3:0] OP_STOP     = 4'd6;
    localparam logic [3:0] OP_RESET    = 4'd7;
    localparam logic [3:0] OP_GET_TIME = 4'd8;
    localparam logic [3:0] OP_STATUS   = 4'd9;
    localparam logic [3:0] OP_ACK      = 4'd10;

    // time units
    localparam logic [1:0] UNIT_MS   = 2'd0;
    localparam logic [1:0] UNIT_S    = 2'd1;
    localparam logic [1:0] UNIT_MIN  = 2'd2;
    localparam logic [1:0] UNIT_HOUR = 2'd3;

    typedef enum logic [1:0] {
        ST_STOPPED  = 2'd0,
        ST_RUNNING  = 2'd1,
        ST_PAUSED   = 2'd2,
        ST_OVERFLOW = 2'd3
    } tmb_status_t;

    typedef enum logic [2:0] {
        FSM_IDLE,
        FSM_TICK,
        FSM_READ,
        FSM_DECODE,
        FSM_MUL1,
        FSM_MUL2,
        FSM_FINISH,
        FSM_RESP
    } tmb_fsm_t;

    localparam int MIN_W  = 22;
    localparam int MS_W   = 16;
    localparam int MUL_W  = 24;
    localparam int PROD_W = 2 * MUL_W;
    localparam int REM_W  = 28;

    localparam logic [MS_W-1:0]  MS_BORROW   = 16'd59999;
    localparam logic [MS_W-1:0]  MS_PER_MIN  = 16'd60000;
    localparam logic [MS_W-1:0]  HALF_MIN_MS = 16'd30000;
    localparam logic [MUL_W-1:0] MS_PER_S    = 24'd1000;
    localparam logic [MUL_W-1:0] SIXTY       = 24'd60;

    // reciprocal multipliers: x / d == (x * R) >> SH over the operand range
    localparam logic [MUL_W-1:0] RECIP_T60   = 24'd34953;    // 16-bit time / 60
    localparam int               T60_SH      = 21;
    localparam logic [MUL_W-1:0] RECIP_MS1K  = 24'd67109;    // 16-bit ms / 1000
    localparam int               MS1K_SH     = 26;
    localparam logic [MUL_W-1:0] RECIP_M60   = 24'd4473925;  // 22-bit minutes / 60
    localparam int               M60_SH      = 28;

    typedef struct packed {
        logic [3:0]  operation;
        logic [3:0]  timer_index;
        logic [15:0] time_value;
        logic [1:0]  unit;
        logic        cyclic_mode;
    } tmb_req_t;

    typedef struct packed {
        logic [15:0] elapsed_reading;
        logic [1:0]  timer_state;
        logic        bad_slot;
        logic [15:0] expired_mask;
        logic        timeout_seen;
    } tmb_rsp_t;

    // one timer record; rl_* is the reload count worked out at set_time
    typedef struct packed {
        logic             cyclic;
        logic [1:0]       unit;
        tmb_status_t      status;
        logic [15:0]      programmed;
        logic [MIN_W-1:0] min_left;
        logic [MS_W-1:0]  ms_left;
        logic [MIN_W-1:0] rl_min;
        logic [MS_W-1:0]  rl_ms;
    } tmb_rec_t;

    typedef struct packed {
        logic             en;
        logic [MUL_W-1:0] a;
        logic [MUL_W-1:0] b;
    } tmb_mul_req_t;

endpackage

@@ rtl/core/tmb_req_if.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Timer bank request channel
// Valid/ready channel carrying one timer request.
// ----------------------------------------------------------------------------
interface tmb_req_if;
    logic        valid;
    logic        ready;
    logic [3:0]  operation;
    logic [3:0]  timer_index;
    logic [15:0] time_value;
    logic [1:0]  unit;
    logic        cyclic_mode;

    modport source (
        output valid,
        output operation,
        output timer_index,
        output time_value,
        output unit,
        output cyclic_mode,
        input  ready
    );

    modport sink (
        input  valid,
        input  operation,
        input  timer_index,
        input  time_value,
        input  unit,
        input  cyclic_mode,
        output ready
    );
endinterface

@@ rtl/core/tmb_rsp_if.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Timer bank response channel
// Valid/ready channel carrying one result per request.
// ----------------------------------------------------------------------------
interface tmb_rsp_if;
    logic        valid;
    logic        ready;
    logic [15:0] elapsed_reading;
    logic [1:0]  timer_state;
    logic        bad_slot;
    logic [15:0] expired_mask;
    logic        timeout_seen;

    modport source (
        output valid,
        output elapsed_reading,
        output timer_state,
        output bad_slot,
        output expired_mask,
        output timeout_seen,
        input  ready
    );

    modport sink (
        input  valid,
        input  elapsed_reading,
        input  timer_state,
        input  bad_slot,
        input  expired_mask,
        input  timeout_seen,
        output ready
    );
endinterface

@@ rtl/core/tmb_slot_ram.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Timer record memory
// One write port, one registered read port, one record per timer slot.
// ----------------------------------------------------------------------------
module tmb_slot_ram #(
    parameter int NUM_TIMERS = 16
) (
    input  logic                 clk,
    input  logic                 we,
    input  logic [(NUM_TIMERS > 1 ? $clog2(NUM_TIMERS) : 1)-1:0] waddr,
    input  tmb_pkg::tmb_rec_t    wdata,
    input  logic                 re,
    input  logic [(NUM_TIMERS > 1 ? $clog2(NUM_TIMERS) : 1)-1:0] raddr,
    output tmb_pkg::tmb_rec_t    rdata
);
    import tmb_pkg::*;

    tmb_rec_t mem [NUM_TIMERS];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

@@ rtl/core/tmb_mul.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Shared multiplier
// Registered 24x24 product; holds its value when not enabled.
// ----------------------------------------------------------------------------
module tmb_mul (
    input  logic                       clk,
    input  tmb_pkg::tmb_mul_req_t      mul_req,
    output logic [tmb_pkg::PROD_W-1:0] product
);
    import tmb_pkg::*;

    logic [PROD_W-1:0] product_reg;

    always_ff @(posedge clk)
    begin
        if (mul_req.en)
        begin
            product_reg <= PROD_W'(mul_req.a) * PROD_W'(mul_req.b);
        end
    end

    assign product = product_reg;

endmodule

@@ rtl/core/tmb_ctrl.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Timer bank sequencer
// Walks the record memory on tick, runs slot commands (set/get time in seconds
// and hours through the shared multiplier), keeps the slot valid bits.
// ----------------------------------------------------------------------------
module tmb_ctrl #(
    parameter int NUM_TIMERS = 16
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       in_valid,
    output logic                       in_ready,
    input  tmb_pkg::tmb_req_t          in_req,
    output logic                       res_valid,
    input  logic                       res_ready,
    output tmb_pkg::tmb_rsp_t          res,
    output tmb_pkg::tmb_mul_req_t      mul_req,
    input  logic [tmb_pkg::PROD_W-1:0] mul_p,
    output logic                       ram_we,
    output logic [(NUM_TIMERS > 1 ? $clog2(NUM_TIMERS) : 1)-1:0] ram_waddr,
    output tmb_pkg::tmb_rec_t          ram_wdata,
    output logic                       ram_re,
    output logic [(NUM_TIMERS > 1 ? $clog2(NUM_TIMERS) : 1)-1:0] ram_raddr,
    input  tmb_pkg::tmb_rec_t          ram_rdata
);
    import tmb_pkg::*;

    localparam int AW   = (NUM_TIMERS > 1) ? $clog2(NUM_TIMERS) : 1;
    localparam int CW   = $clog2(NUM_TIMERS + 1);
    localparam int IDXW = 7;

    tmb_fsm_t               state_reg, state_next;
    tmb_req_t               req_reg, req_next;
    logic [NUM_TIMERS-1:0]  valid_reg, valid_next;
    logic [CW-1:0]          walk_cnt_reg, walk_cnt_next;
    logic                   proc_vld_reg, proc_vld_next;
    logic [AW-1:0]          proc_idx_reg, proc_idx_next;
    logic [15:0]            mask_reg, mask_next;
    logic [REM_W-1:0]       sc_reg, sc_next;
    tmb_rsp_t               res_reg, res_next;

    logic [IDXW-1:0]        idx_w;
    logic [AW-1:0]          slot_addr;
    logic                   in_range;
    logic                   exists;
    logic                   op_known;
    logic                   cmd_ok;
    logic                   is_set;
    logic                   is_get;
    logic                   needs_mul;

    tmb_rec_t               tick_rec;
    logic                   tick_exp;
    logic [IDXW-1:0]        proc_idx_w;
    logic [15:0]            tick_bit;

    tmb_rec_t               fin_rec;
    tmb_rsp_t               fin_res;
    logic [MIN_W-1:0]       set_min;
    logic [MS_W-1:0]        set_ms;
    logic [REM_W-1:0]       rem;
    logic [15:0]            elapsed;

    // ---- request decode ----
    assign idx_w     = {3'b000, req_reg.timer_index};
    assign slot_addr = idx_w[AW-1:0];
    assign in_range  = idx_w < IDXW'(NUM_TIMERS);
    assign exists    = in_range && valid_reg[slot_addr];
    assign op_known  = req_reg.operation <= OP_ACK;
    assign cmd_ok    = ((req_reg.operation == OP_CREATE) && in_range) || exists;
    assign is_set    = req_reg.operation == OP_SET_TIME;
    assign is_get    = req_reg.operation == OP_GET_TIME;
    // seconds and hours need the multiplier
    assign needs_mul = (is_set || is_get) && req_reg.unit[0];

    // ---- one slot of the tick walk ----
    always_comb
    begin
        tick_rec = ram_rdata;
        tick_exp = 1'b0;
        if (valid_reg[proc_idx_reg] && (ram_rdata.status == ST_RUNNING))
        begin
            if (ram_rdata.ms_left != '0)
            begin
                tick_rec.ms_left = ram_rdata.ms_left - MS_W'(1);
            end
            else if (ram_rdata.min_left != '0)
            begin
                tick_rec.min_left = ram_rdata.min_left - MIN_W'(1);
                tick_rec.ms_left  = MS_BORROW;
            end
            else
            begin
                tick_exp = 1'b1;
                if (ram_rdata.cyclic)
                begin
                    tick_rec.min_left = ram_rdata.rl_min;
                    tick_rec.ms_left  = ram_rdata.rl_ms;
                end
                else
                begin
                    tick_rec.status = ST_OVERFLOW;
                end
            end
        end
    end

    assign proc_idx_w = {{(IDXW-AW){1'b0}}, proc_idx_reg};
    assign tick_bit   = (tick_exp && (proc_idx_w < IDXW'(16)))
                      ? (16'd1 << proc_idx_w[3:0]) : 16'd0;

    // ---- command completion ----
    always_comb
    begin
        set_min = '0;
        set_ms  = req_reg.time_value;
        unique case (req_reg.unit)
            UNIT_MS:
            begin
                set_min = '0;
                set_ms  = req_reg.time_value;
            end
            UNIT_S:
            begin
                set_min = sc_reg[MIN_W-1:0];
                set_ms  = mul_p[MS_W-1:0];
            end
            UNIT_MIN:
            begin
                if (req_reg.time_value != '0)
                begin
                    set_min = MIN_W'(req_reg.time_value) - MIN_W'(1);
                    set_ms  = MS_PER_MIN;
                end
                else
                begin
                    set_ms = '0;
                end
            end
            UNIT_HOUR:
            begin
                if (req_reg.time_value != '0)
                begin
                    set_min = mul_p[MIN_W-1:0] - MIN_W'(1);
                    set_ms  = MS_PER_MIN;
                end
                else
                begin
                    set_ms = '0;
                end
            end
        endcase
    end

    always_comb
    begin
        unique case (req_reg.unit)
            UNIT_MS:   rem = REM_W'(ram_rdata.ms_left);
            UNIT_S:    rem = mul_p[REM_W-1:0] + sc_reg;
            UNIT_MIN:  rem = REM_W'(ram_rdata.min_left);
            UNIT_HOUR: rem = REM_W'(mul_p[M60_SH +: 17]);
        endcase
        elapsed = (REM_W'(ram_rdata.programmed) > rem)
                ? (ram_rdata.programmed - rem[15:0]) : 16'd0;
        // minutes and hours: half a minute or more left rounds down by one
        if (req_reg.unit[1] && (ram_rdata.ms_left >= HALF_MIN_MS) && (elapsed != '0))
        begin
            elapsed = elapsed - 16'd1;
        end
    end

    always_comb
    begin
        fin_rec = ram_rdata;
        fin_res = '0;
        unique case (req_reg.operation)
            OP_CREATE:
            begin
                fin_rec        = '0;
                fin_rec.cyclic = req_reg.cyclic_mode;
            end
            OP_DELETE:
            begin
                fin_rec.status = ST_STOPPED;
            end
            OP_SET_TIME:
            begin
                fin_rec.programmed = req_reg.time_value;
                fin_rec.unit       = req_reg.unit;
                fin_rec.rl_min     = set_min;
                fin_rec.rl_ms      = set_ms;
                fin_rec.min_left   = set_min;
                fin_rec.ms_left    = set_ms;
            end
            OP_START:
            begin
                fin_rec.status = ST_RUNNING;
            end
            OP_PAUSE:
            begin
                fin_rec.status = ST_PAUSED;
            end
            OP_STOP:
            begin
                fin_rec.status   = ST_STOPPED;
                fin_rec.min_left = ram_rdata.rl_min;
                fin_rec.ms_left  = ram_rdata.rl_ms;
            end
            OP_RESET:
            begin
                fin_rec.min_left = ram_rdata.rl_min;
                fin_rec.ms_left  = ram_rdata.rl_ms;
            end
            OP_GET_TIME:
            begin
                fin_res.elapsed_reading = elapsed;
            end
            OP_ACK:
            begin
                if (ram_rdata.status == ST_OVERFLOW)
                begin
                    fin_res.timeout_seen = 1'b1;
                    if (ram_rdata.cyclic)
                    begin
                        fin_rec.status   = ST_RUNNING;
                        fin_rec.min_left = ram_rdata.rl_min;
                        fin_rec.ms_left  = ram_rdata.rl_ms;
                    end
                    else
                    begin
                        fin_rec.status = ST_STOPPED;
                    end
                end
            end
            default:
            begin
                // status read: no change
            end
        endcase
        fin_res.timer_state = fin_rec.status;
    end

    // ---- next state ----
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            FSM_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = (in_req.operation == OP_TICK) ? FSM_TICK : FSM_READ;
                end
            end
            FSM_TICK:
            begin
                if (!proc_vld_reg && (walk_cnt_reg == CW'(NUM_TIMERS)))
                begin
                    state_next = FSM_RESP;
                end
            end
            FSM_READ:
            begin
                state_next = FSM_DECODE;
            end
            FSM_DECODE:
            begin
                priority if (!op_known || !cmd_ok)
                begin
                    state_next = FSM_RESP;
                end
                else if (needs_mul)
                begin
                    state_next = FSM_MUL1;
                end
                else
                begin
                    state_next = FSM_FINISH;
                end
            end
            FSM_MUL1:
            begin
                state_next = req_reg.unit[1] ? FSM_FINISH : FSM_MUL2;
            end
            FSM_MUL2:
            begin
                state_next = FSM_FINISH;
            end
            FSM_FINISH:
            begin
                state_next = FSM_RESP;
            end
            FSM_RESP:
            begin
                if (res_ready)
                begin
                    state_next = FSM_IDLE;
                end
            end
        endcase
    end

    // ---- outputs and datapath ----
    always_comb
    begin
        req_next      = req_reg;
        valid_next    = valid_reg;
        walk_cnt_next = walk_cnt_reg;
        proc_vld_next = 1'b0;
        proc_idx_next = proc_idx_reg;
        mask_next     = mask_reg;
        sc_next       = sc_reg;
        res_next      = res_reg;
        in_ready      = 1'b0;
        res_valid     = 1'b0;
        ram_re        = 1'b0;
        ram_raddr     = slot_addr;
        ram_we        = 1'b0;
        ram_waddr     = slot_addr;
        ram_wdata     = fin_rec;
        mul_req       = '0;

        unique case (state_reg)
            FSM_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    req_next      = in_req;
                    walk_cnt_next = '0;
                    mask_next     = '0;
                    res_next      = '0;
                end
            end
            FSM_TICK:
            begin
                // read slot n while slot n-1 is written back
                if (walk_cnt_reg < CW'(NUM_TIMERS))
                begin
                    ram_re        = 1'b1;
                    ram_raddr     = walk_cnt_reg[AW-1:0];
                    proc_vld_next = 1'b1;
                    proc_idx_next = walk_cnt_reg[AW-1:0];
                    walk_cnt_next = walk_cnt_reg + CW'(1);
                end
                if (proc_vld_reg)
                begin
                    ram_we    = 1'b1;
                    ram_waddr = proc_idx_reg;
                    ram_wdata = tick_rec;
                    mask_next = mask_reg | tick_bit;
                end
                res_next              = '0;
                res_next.expired_mask = mask_next;
            end
            FSM_READ:
            begin
                ram_re = 1'b1;
            end
            FSM_DECODE:
            begin
                res_next = '0;
                if (op_known && !cmd_ok)
                begin
                    res_next.bad_slot = 1'b1;
                end
                if (op_known && cmd_ok && needs_mul)
                begin
                    mul_req.en = 1'b1;
                    unique case ({is_get, req_reg.unit[1]})
                        2'b00:
                        begin
                            mul_req.a = MUL_W'(req_reg.time_value);
                            mul_req.b = RECIP_T60;
                        end
                        2'b01:
                        begin
                            mul_req.a = MUL_W'(req_reg.time_value);
                            mul_req.b = SIXTY;
                        end
                        2'b10:
                        begin
                            mul_req.a = MUL_W'(ram_rdata.ms_left);
                            mul_req.b = RECIP_MS1K;
                        end
                        2'b11:
                        begin
                            mul_req.a = MUL_W'(ram_rdata.min_left);
                            mul_req.b = RECIP_M60;
                        end
                    endcase
                end
            end
            FSM_MUL1:
            begin
                if (!req_reg.unit[1])
                begin
                    mul_req.en = 1'b1;
                    mul_req.b  = SIXTY;
                    if (is_get)
                    begin
                        sc_next   = REM_W'(mul_p[MS1K_SH +: 7]);
                        mul_req.a = MUL_W'(ram_rdata.min_left);
                    end
                    else
                    begin
                        sc_next   = REM_W'(mul_p[T60_SH +: 11]);
                        mul_req.a = MUL_W'(mul_p[T60_SH +: 11]);
                    end
                end
            end
            FSM_MUL2:
            begin
                // seconds remainder times 1000
                if (is_set)
                begin
                    mul_req.en = 1'b1;
                    mul_req.a  = MUL_W'(req_reg.time_value - mul_p[15:0]);
                    mul_req.b  = MS_PER_S;
                end
            end
            FSM_FINISH:
            begin
                ram_we   = 1'b1;
                res_next = fin_res;
                if (req_reg.operation == OP_CREATE)
                begin
                    valid_next[slot_addr] = 1'b1;
                end
                if (req_reg.operation == OP_DELETE)
                begin
                    valid_next[slot_addr] = 1'b0;
                end
            end
            FSM_RESP:
            begin
                res_valid = 1'b1;
            end
        endcase
    end

    assign res = res_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= FSM_IDLE;
            valid_reg    <= '0;
            walk_cnt_reg <= '0;
            proc_vld_reg <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            valid_reg    <= valid_next;
            walk_cnt_reg <= walk_cnt_next;
            proc_vld_reg <= proc_vld_next;
        end
    end

    always_ff @(posedge clk)
    begin
        req_reg      <= req_next;
        proc_idx_reg <= proc_idx_next;
        mask_reg     <= mask_next;
        sc_reg       <= sc_next;
        res_reg      <= res_next;
    end

endmodule

@@ rtl/core/multi_channel_unit_timer_bank.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Multi-channel unit timer bank
// Bank of millisecond timers driven by tick and slot-command requests.
// ----------------------------------------------------------------------------
// Usage:
//   req  - one request per handshake: a tick (counts down every running
//          timer) or a command on one timer slot (create, delete, set time,
//          start, pause, stop, reset, get time, status, timeout ack).
//   rsp  - exactly one result per request, in request order; a tick returns
//          the mask of timers that expired on it.
// Timing:
//   One request at a time; req.ready is low while it is worked on.
//   Tick: walks the record memory, one slot read and one written back per
//   cycle, then responds.
//   Commands: read, decode, update, respond; set/get time in hours add the
//   MUL1 step, in seconds MUL1 and MUL2, serialized on the one shared
//   multiplier. A bad slot or unknown code skips to respond after decode.
// Reset:
//   All slots not created; no clearing pass, valid bits clear at once.
// Stall:
//   The result sits in an output register. The next request is accepted
//   while it waits; that request's own result waits until rsp is taken.
// ----------------------------------------------------------------------------
module multi_channel_unit_timer_bank #(
    parameter int NUM_TIMERS = 16
) (
    input logic   clk,
    input logic   rst_n,
    tmb_req_if.sink   req,
    tmb_rsp_if.source rsp
);
    import tmb_pkg::*;

    localparam int AW = (NUM_TIMERS > 1) ? $clog2(NUM_TIMERS) : 1;

    // request payload gathered into one struct
    tmb_req_t      req_data;

    // sequencer <-> output register
    logic          res_valid;
    logic          res_ready;
    tmb_rsp_t      res_data;

    // sequencer <-> shared multiplier
    tmb_mul_req_t  mul_req;
    logic [PROD_W-1:0] mul_p;

    // sequencer <-> record memory
    logic          ram_we;
    logic [AW-1:0] ram_waddr;
    tmb_rec_t      ram_wdata;
    logic          ram_re;
    logic [AW-1:0] ram_raddr;
    tmb_rec_t      ram_rdata;

    // output register
    logic          out_valid_reg, out_valid_next;
    tmb_rsp_t      out_data_reg, out_data_next;

    assign req_data.operation   = req.operation;
    assign req_data.timer_index = req.timer_index;
    assign req_data.time_value  = req.time_value;
    assign req_data.unit        = req.unit;
    assign req_data.cyclic_mode = req.cyclic_mode;

    tmb_ctrl #(
        .NUM_TIMERS (NUM_TIMERS)
    ) u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (req.valid),
        .in_ready  (req.ready),
        .in_req    (req_data),
        .res_valid (res_valid),
        .res_ready (res_ready),
        .res       (res_data),
        .mul_req   (mul_req),
        .mul_p     (mul_p),
        .ram_we    (ram_we),
        .ram_waddr (ram_waddr),
        .ram_wdata (ram_wdata),
        .ram_re    (ram_re),
        .ram_raddr (ram_raddr),
        .ram_rdata (ram_rdata)
    );

    tmb_mul u_mul (
        .clk     (clk),
        .mul_req (mul_req),
        .product (mul_p)
    );

    tmb_slot_ram #(
        .NUM_TIMERS (NUM_TIMERS)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // the register is free when empty or being drained this cycle
    assign res_ready = !out_valid_reg || rsp.ready;

    always_comb
    begin
        out_valid_next = out_valid_reg;
        out_data_next  = out_data_reg;
        if (res_valid && res_ready)
        begin
            out_valid_next = 1'b1;
            out_data_next  = res_data;
        end
        else if (rsp.ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_data_reg <= out_data_next;
    end

    assign rsp.valid           = out_valid_reg;
    assign rsp.elapsed_reading = out_data_reg.elapsed_reading;
    assign rsp.timer_state     = out_data_reg.timer_state;
    assign rsp.bad_slot        = out_data_reg.bad_slot;
    assign rsp.expired_mask    = out_data_reg.expired_mask;
    assign rsp.timeout_seen    = out_data_reg.timeout_seen;

    // ---- checks ----

    // one request at a time: busy right after an accept
    a_busy_after_accept: assert property (
        @(posedge clk) disable iff (!rst_n)
        (req.valid && req.ready) |=> !req.ready
    ) else $error("request accepted while a previous one is in progress");

    // a bad slot result carries nothing else
    a_bad_slot_clean: assert property (
        @(posedge clk) disable iff (!rst_n)
        (rsp.valid && rsp.bad_slot) |->
            (rsp.elapsed_reading == '0) && (rsp.timer_state == '0) &&
            (rsp.expired_mask == '0) && (rsp.timeout_seen == 1'b0)
    ) else $error("bad slot result with other fields set");

    // a cleared timeout leaves the slot stopped or running again
    a_ack_state: assert property (
        @(posedge clk) disable iff (!rst_n)
        (rsp.valid && rsp.timeout_seen) |->
            (rsp.timer_state == ST_STOPPED) || (rsp.timer_state == ST_RUNNING)
    ) else $error("timeout ack left slot in a wrong state");

    // no expiry reported for a slot that does not exist
    a_mask_range: assert property (
        @(posedge clk) disable iff (!rst_n)
        rsp.valid |-> ((32'(rsp.expired_mask) >> NUM_TIMERS) == 32'd0)
    ) else $error("expired mask bit beyond the timer count");

endmodule
